[hw/rtl/nlc_pkg.sv]
// Package for the number literal classifier: item types, phase codes and
// character constants. No dependencies.
`default_nettype none

package nlc_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       no_char;
    logic       last;
  } nlc_in_t;

  typedef struct packed {
    logic unsigned_ok;
    logic integer_ok;
    logic fraction_ok;
    logic exponent_ok;
  } nlc_out_t;

  typedef enum logic [10:0] {
    PhStart = 11'b000_0000_0001,
    PhMinus = 11'b000_0000_0010,
    PhZero  = 11'b000_0000_0100,
    PhInt   = 11'b000_0000_1000,
    PhPoint = 11'b000_0001_0000,
    PhFrac  = 11'b000_0010_0000,
    PhEmark = 11'b000_0100_0000,
    PhEsign = 11'b000_1000_0000,
    PhEzero = 11'b001_0000_0000,
    PhEdig  = 11'b010_0000_0000,
    PhFail  = 11'b100_0000_0000
  } nlc_phase_e;

  typedef struct packed {
    nlc_phase_e phase;
    logic       neg;
  } nlc_state_t;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPoint = 8'h2e;
  localparam logic [7:0] CharLowE  = 8'h65;
  localparam logic [7:0] CharUpE   = 8'h45;
  localparam logic [7:0] CharPlus  = 8'h2b;

endpackage

`default_nettype wire

[hw/rtl/nlc_step.sv]
// Transition table of the classifier: next state and result flags for one item.
// Depends on nlc_pkg.
`default_nettype none

module nlc_step (
  input  wire nlc_pkg::nlc_state_t state_i,
  input  wire nlc_pkg::nlc_in_t    item_i,
  output nlc_pkg::nlc_state_t      state_o,
  output nlc_pkg::nlc_out_t        result_o
);
  import nlc_pkg::*;

  logic [7:0] c;
  logic       is_num;
  logic       is_zero;
  logic       is_emark;
  nlc_phase_e ph_next;
  nlc_phase_e ph_upd;
  logic       neg_upd;
  logic       is_i;
  logic       is_f;
  logic       is_d;

  assign c        = item_i.symbol;
  assign is_num   = c inside {[CharZero:CharNine]};
  assign is_zero  = (c == CharZero);
  assign is_emark = (c == CharLowE) || (c == CharUpE);

  always_comb begin
    ph_next = PhFail;
    case (state_i.phase)
      PhStart, PhMinus: begin
        if ((state_i.phase == PhStart) && (c == CharMinus)) ph_next = PhMinus;
        else if (is_zero) ph_next = PhZero;
        else if (is_num) ph_next = PhInt;
      end
      PhZero: begin
        if (c == CharPoint) ph_next = PhPoint;
        else if (is_emark) ph_next = PhEmark;
      end
      PhInt: begin
        if (is_num) ph_next = PhInt;
        else if (c == CharPoint) ph_next = PhPoint;
        else if (is_emark) ph_next = PhEmark;
      end
      PhPoint, PhFrac: begin
        if (is_num) ph_next = PhFrac;
        else if (is_emark) ph_next = PhEmark;
      end
      PhEmark, PhEsign: begin
        if ((state_i.phase == PhEmark) && ((c == CharMinus) || (c == CharPlus))) begin
          ph_next = PhEsign;
        end else if (is_zero) ph_next = PhEzero;
        else if (is_num) ph_next = PhEdig;
      end
      PhEdig: begin
        if (is_num) ph_next = PhEdig;
      end
      default: ph_next = PhFail;
    endcase
  end

  always_comb begin
    ph_upd  = state_i.phase;
    neg_upd = state_i.neg;
    if (!item_i.no_char) begin
      ph_upd = ph_next;
      if ((state_i.phase == PhStart) && (c == CharMinus)) neg_upd = 1'b1;
    end
  end

  assign is_i = (ph_upd == PhZero) || (ph_upd == PhInt);
  assign is_f = is_i || (ph_upd == PhPoint) || (ph_upd == PhFrac);
  assign is_d = is_f || (ph_upd == PhEzero) || (ph_upd == PhEdig);

  assign result_o.unsigned_ok = is_i && !neg_upd;
  assign result_o.integer_ok  = is_i;
  assign result_o.fraction_ok = is_f;
  assign result_o.exponent_ok = is_d;

  always_comb begin
    if (item_i.last) begin
      state_o.phase = PhStart;
      state_o.neg   = 1'b0;
    end else begin
      state_o.phase = ph_upd;
      state_o.neg   = neg_upd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/number_literal_classifier_core.sv]
// Number literal classifier top level: input register, token state, result register.
// Depends on nlc_pkg and nlc_step.
//
// Classifies a number literal that arrives one character per item and ends on
// the item marked last, then returns one result item with four nested flags
// (unsigned, integer, fraction form, exponent form). An item with no_char set
// carries no character; with last set at the start of a token it yields an
// all-zero result. One item is accepted per clock cycle while no last item
// waits in the input register for the result register to free up. The token
// state update is a single combinational transition table between the input
// register and the result register, so only results not yet taken stall input.
`default_nettype none

module number_literal_classifier_core (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire  nlc_pkg::nlc_in_t   in_item_i,
  output logic                     out_valid_o,
  input  wire                logic out_ready_i,
  output nlc_pkg::nlc_out_t        out_item_o
);
  import nlc_pkg::*;

  logic       in_valid_q;
  nlc_in_t    in_q;
  nlc_state_t state_q;
  nlc_state_t state_d;
  nlc_out_t   result_d;
  nlc_out_t   out_q;
  logic       out_valid_q;
  logic       out_free;
  logic       consume;

  nlc_step u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign consume    = in_valid_q && (out_free || !in_q.last);
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      state_q.phase <= PhStart;
      state_q.neg   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (consume) state_q <= state_d;
      if (consume && in_q.last) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
    if (consume && in_q.last) out_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_flags_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_item_o.unsigned_ok || out_item_o.integer_ok) &&
                     (!out_item_o.integer_ok || out_item_o.fraction_ok) &&
                     (!out_item_o.fraction_ok || out_item_o.exponent_ok)))
    else $error("result flags not nested");

  a_token_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_q.last) |=> (state_q.phase == PhStart && !state_q.neg))
    else $error("state not cleared after token end");

  a_neg_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.neg |-> (state_q.phase != PhStart))
    else $error("minus flag set at token start");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && in_q.last && out_valid_q))
    else $error("input stalled without a pending last item");

endmodule

`default_nettype wire

[bench/nlc_checker.sv]
// Checker for the number literal classifier: watches both item channels,
// predicts the four flags of each token and compares. Depends on nlc_pkg.
module nlc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  nlc_pkg::nlc_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  nlc_pkg::nlc_out_t out_item_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nlc_pkg::*;

  nlc_phase_e tok_phase;
  logic       tok_neg;
  nlc_out_t   flags_q[$];
  int         fails = 0;
  int         pend  = 0;
  int         chk   = 0;

  assign fail_count_o = fails;
  assign pending_o    = pend;
  assign checked_o    = chk;

  function automatic logic is_dec_char(logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_exp_mark(logic [7:0] c);
    return (c == CharLowE) || (c == CharUpE);
  endfunction

  function automatic nlc_phase_e digit_entry(logic [7:0] c, nlc_phase_e zero_ph,
                                             nlc_phase_e dig_ph);
    if (c == CharZero) return zero_ph;
    if (is_dec_char(c)) return dig_ph;
    return PhFail;
  endfunction

  function automatic nlc_phase_e next_phase(nlc_phase_e ph, logic [7:0] c);
    case (ph)
      PhStart: begin
        if (c == CharMinus) return PhMinus;
        return digit_entry(c, PhZero, PhInt);
      end
      PhMinus: return digit_entry(c, PhZero, PhInt);
      PhZero: begin
        if (c == CharPoint) return PhPoint;
        if (is_exp_mark(c)) return PhEmark;
        return PhFail;
      end
      PhInt: begin
        if (is_dec_char(c)) return PhInt;
        if (c == CharPoint) return PhPoint;
        if (is_exp_mark(c)) return PhEmark;
        return PhFail;
      end
      PhPoint, PhFrac: begin
        if (is_dec_char(c)) return PhFrac;
        if (is_exp_mark(c)) return PhEmark;
        return PhFail;
      end
      PhEmark: begin
        if ((c == CharMinus) || (c == CharPlus)) return PhEsign;
        return digit_entry(c, PhEzero, PhEdig);
      end
      PhEsign: return digit_entry(c, PhEzero, PhEdig);
      PhEdig:  return is_dec_char(c) ? PhEdig : PhFail;
      default: return PhFail;
    endcase
  endfunction

  task automatic report(string msg);
    fails++;
    if (fails <= 20) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_flag(string name, logic got, logic want);
    if (got !== want)
      report($sformatf("result %0d: %s got %b want %b", chk, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    nlc_out_t want;
    logic     is_int;
    logic     is_frac;
    logic     is_exp;
    if (!rst_ni) begin
      tok_phase = PhStart;
      tok_neg   = 1'b0;
      flags_q.delete();
      pend = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        chk++;
        if (flags_q.size() == 0) begin
          report($sformatf("result %0d arrived with no token pending", chk));
        end else begin
          want = flags_q.pop_front();
          check_flag("unsigned_ok", out_item_i.unsigned_ok, want.unsigned_ok);
          check_flag("integer_ok", out_item_i.integer_ok, want.integer_ok);
          check_flag("fraction_ok", out_item_i.fraction_ok, want.fraction_ok);
          check_flag("exponent_ok", out_item_i.exponent_ok, want.exponent_ok);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (!in_item_i.no_char) begin
          if ((tok_phase == PhStart) && (in_item_i.symbol == CharMinus)) tok_neg = 1'b1;
          tok_phase = next_phase(tok_phase, in_item_i.symbol);
        end
        if (in_item_i.last) begin
          is_int  = (tok_phase == PhZero) || (tok_phase == PhInt);
          is_frac = is_int || (tok_phase == PhPoint) || (tok_phase == PhFrac);
          is_exp  = is_frac || (tok_phase == PhEzero) || (tok_phase == PhEdig);
          want.unsigned_ok = is_int && !tok_neg;
          want.integer_ok  = is_int;
          want.fraction_ok = is_frac;
          want.exponent_ok = is_exp;
          flags_q.push_back(want);
          tok_phase = PhStart;
          tok_neg   = 1'b0;
        end
      end
      pend = flags_q.size();
    end
  end

endmodule

[bench/tb.sv]
// Top of the number literal classifier bench: clock, reset, token stimulus
// with random gaps and output stalls, and the verdict. Depends on nlc_pkg,
// nlc_checker and number_literal_classifier_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nlc_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  nlc_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_ready_i;
  nlc_out_t out_item_o;

  int fail_count;
  int pending;
  int checked;

  int         n_items = 0;
  int         n_tokens = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] token_q[$];

  always #4 clk_i = ~clk_i;

  number_literal_classifier_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  nlc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  function automatic int pick_gap();
    int unsigned r;
    if (hold_req && !hold_done) return 0;
    if ((n_items >= 100) && (n_items < 160)) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_digit(bit nonzero);
    return CharZero + 8'($urandom_range(nonzero ? 1 : 0, 9));
  endfunction

  function automatic logic [7:0] rand_special();
    case ($urandom_range(0, 5))
      0: return CharMinus;
      1: return CharPoint;
      2: return CharLowE;
      3: return CharUpE;
      4: return CharPlus;
      default: return CharZero;
    endcase
  endfunction

  task automatic send_item(logic [7:0] sym, logic nc, logic lst);
    int      gap;
    nlc_in_t it;
    gap = pick_gap();
    it.symbol  = sym;
    it.no_char = nc;
    it.last    = lst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!(nc && !lst)) n_items++;
    if (n_items >= 300) hold_req = 1'b1;
  endtask

  // Sends token_q; blanks may be slipped in, and the end may be a blank item.
  task automatic send_token(bit blanks);
    bit blank_end;
    blank_end = blanks && ($urandom_range(0, 9) == 0);
    n_tokens++;
    if (token_q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    foreach (token_q[i]) begin
      if (blanks && ($urandom_range(0, 14) == 0))
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(token_q[i], 1'b0, !blank_end && (i == token_q.size() - 1));
    end
    if (blank_end) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic send_str(string s);
    token_q.delete();
    for (int i = 0; i < s.len(); i++) token_q.push_back(s[i]);
    send_token(1'b0);
  endtask

  task automatic build_token();
    int unsigned kind;
    int unsigned idx;
    int unsigned n;
    token_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) token_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) token_q.push_back(CharMinus);
    if ($urandom_range(0, 4) == 0) begin
      token_q.push_back(CharZero);
    end else begin
      token_q.push_back(rand_digit(1'b1));
      repeat ($urandom_range(0, 3)) token_q.push_back(rand_digit(1'b0));
    end
    if ($urandom_range(0, 2) == 0) begin
      token_q.push_back(CharPoint);
      repeat ($urandom_range(0, 3)) token_q.push_back(rand_digit(1'b0));
    end
    if ($urandom_range(0, 2) == 0) begin
      token_q.push_back($urandom_range(0, 1) ? CharLowE : CharUpE);
      case ($urandom_range(0, 3))
        1: token_q.push_back(CharPlus);
        2: token_q.push_back(CharMinus);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        token_q.push_back(CharZero);
      end else begin
        token_q.push_back(rand_digit(1'b1));
        repeat ($urandom_range(0, 2)) token_q.push_back(rand_digit(1'b0));
      end
    end
    if (kind >= 80) begin
      idx = $urandom_range(0, token_q.size() - 1);
      case ($urandom_range(0, 3))
        0: token_q[idx] = 8'($urandom_range(0, 255));
        1: token_q.insert(idx, rand_special());
        2: begin
          n = $urandom_range(0, token_q.size() - 1);
          while (token_q.size() > n) void'(token_q.pop_back());
        end
        default: token_q.push_back($urandom_range(0, 1) ? rand_special()
                                                       : 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Output side: random stalls, plus one long hold-off while input keeps coming.
  task automatic run_receiver();
    int hi;
    int lo;
    int unsigned r;
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        hi = ($urandom_range(0, 9) == 0) ? 50 : $urandom_range(1, 20);
        r  = $urandom_range(0, 99);
        if (r < 25)      lo = 0;
        else if (r < 85) lo = $urandom_range(1, 3);
        else if (r < 97) lo = $urandom_range(4, 10);
        else             lo = $urandom_range(20, 40);
        out_ready_i <= 1'b1;
        repeat (hi) @(posedge clk_i);
        if (lo > 0) begin
          out_ready_i <= 1'b0;
          repeat (lo) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      run_receiver();
    join_none

    send_str("0");
    send_str("-9");
    send_str("01");
    send_str("1.05");
    send_str("2e+0");
    send_str("5E-7");
    send_str("1eE2");
    send_str("");
    token_q.delete();
    token_q.push_back(8'hff);
    send_token(1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_str("3");

    while ((n_items < 650) || (hold_req && !hold_done)) begin
      build_token();
      send_token(1'b1);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Classified %0d tokens from %0d items: directed literals, random well-formed",
             n_tokens, n_items);
    $display("and broken tokens, blank items, and a long output hold-off; %0d results checked.",
             checked);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
